// ===== sv/rcpt_pkg.sv =====
// Package for the radius collect point table: sizes, codes and payload types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rcpt_pkg;

  localparam int CAPACITY   = 64;
  localparam int COORD_BITS = 24;

  localparam int POS_W   = 24;
  localparam int TAG_W   = 4;
  localparam int REACH_W = 23;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int R2_W    = 2 * REACH_W;
  localparam int CMP_W   = (SQ_W + 1 > R2_W) ? SQ_W + 1 : R2_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_COLLECT = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAT_HIT     = 3'd0,
    STAT_NONE    = 3'd1,
    STAT_ADDED   = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_CLEARED = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [TAG_W-1:0]         tag_in;
    logic [REACH_W-1:0]       reach;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [TAG_W-1:0] tag_out;
    logic             last;
  } out_t;

  typedef struct packed {
    coord_t           x;
    coord_t           y;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic   vld;
    logic   hit;
    entry_t ent;
  } dec_t;

endpackage

`default_nettype wire

// ===== sv/rcpt_cell.sv =====
// One table cell: holds a single entry, loads a new one or takes its upper neighbor's.
// Depends on rcpt_pkg.
`default_nettype none

module rcpt_cell (
  input  wire                 clk,
  input  rcpt_pkg::cell_ctrl_t ctrl,
  input  rcpt_pkg::entry_t    nbr,
  input  rcpt_pkg::entry_t    load_data,
  output rcpt_pkg::entry_t    q
);
  import rcpt_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.load) begin
      ent_nxt = load_data;
    end else if (ctrl.shift) begin
      ent_nxt = nbr;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign q = ent_r;

endmodule

`default_nettype wire

// ===== sv/rcpt_dist.sv =====
// Distance pipeline: absolute differences, squares, then compare against the squared radius.
// Depends on rcpt_pkg.
`default_nettype none

module rcpt_dist (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     pop,
  input  rcpt_pkg::entry_t        head,
  input  rcpt_pkg::coord_t        qx,
  input  rcpt_pkg::coord_t        qy,
  input  wire [rcpt_pkg::R2_W-1:0] r2,
  output rcpt_pkg::dec_t          dec,
  output logic                    busy
);
  import rcpt_pkg::*;

  logic [COORD_BITS:0]   diff_x, diff_y;
  logic [COORD_BITS-1:0] neg_x, neg_y;
  logic [COORD_BITS-1:0] adx, ady;

  logic                  s1_vld_r;
  entry_t                s1_ent_r;
  logic [COORD_BITS-1:0] s1_dx_r, s1_dy_r;

  logic                  s2_vld_r;
  entry_t                s2_ent_r;
  logic [SQ_W-1:0]       s2_sqx_r, s2_sqy_r;

  logic [CMP_W-1:0]      dist2;

  // sign-extend by one bit so the difference cannot wrap
  assign diff_x = {qx[COORD_BITS-1], qx} - {head.x[COORD_BITS-1], head.x};
  assign diff_y = {qy[COORD_BITS-1], qy} - {head.y[COORD_BITS-1], head.y};
  assign neg_x  = -diff_x[COORD_BITS-1:0];
  assign neg_y  = -diff_y[COORD_BITS-1:0];
  assign adx    = diff_x[COORD_BITS] ? neg_x : diff_x[COORD_BITS-1:0];
  assign ady    = diff_y[COORD_BITS] ? neg_y : diff_y[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= pop;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ent_r <= head;
    s1_dx_r  <= adx;
    s1_dy_r  <= ady;
    s2_ent_r <= s1_ent_r;
    s2_sqx_r <= SQ_W'(s1_dx_r) * SQ_W'(s1_dx_r);
    s2_sqy_r <= SQ_W'(s1_dy_r) * SQ_W'(s1_dy_r);
  end

  assign dist2   = CMP_W'(s2_sqx_r) + CMP_W'(s2_sqy_r);
  assign dec.vld = s2_vld_r;
  assign dec.hit = (dist2 <= CMP_W'(r2));
  assign dec.ent = s2_ent_r;
  assign busy    = s1_vld_r | s2_vld_r;

endmodule

`default_nettype wire

// ===== sv/radius_collect_point_table_core.sv =====
// Radius collect point table: a chain of entry cells feeding a distance pipeline.
// Add, clear and a full add return their one result the cycle after the request; busy stays low.
// A collect holds busy high (empty table: never) while the chain shifts one entry per cycle into the
// distance unit and that unit drains; the final result shows as busy falls.
// Results cannot be stalled. Synchronous active-low reset empties the table; entries are not cleared.
// Depends on rcpt_pkg, rcpt_cell and rcpt_dist.
`default_nettype none

module radius_collect_point_table_core (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  output logic           busy,
  input  rcpt_pkg::in_t  in_data,
  output logic           out_valid,
  output rcpt_pkg::out_t out_data
);
  import rcpt_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  pop_left_r, pop_left_nxt;
  coord_t            qx_r, qx_nxt, qy_r, qy_nxt;
  logic [R2_W-1:0]   r2_r, r2_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [TAG_W-1:0]  pend_tag_r, pend_tag_nxt;
  logic              out_vld_r, out_vld_nxt;
  out_t              out_r, out_nxt;

  logic              accept;
  logic              pop, push;
  entry_t            push_data;
  logic [CNT_W-1:0]  wr_idx;
  dec_t              dec;
  logic              dist_busy;

  entry_t            cell_q [CAPACITY];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // cell chain: each cell shifts down on a pop and loads when it is the write slot
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     nbr;
    assign ctrl.shift = pop;
    assign ctrl.load  = push && (wr_idx == CNT_W'(g));
    if (g == CAPACITY - 1) begin : g_top
      assign nbr = push_data;
    end else begin : g_mid
      assign nbr = cell_q[g+1];
    end
    rcpt_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .nbr       (nbr),
      .load_data (push_data),
      .q         (cell_q[g])
    );
  end

  rcpt_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .pop   (pop),
    .head  (cell_q[0]),
    .qx    (qx_r),
    .qy    (qy_r),
    .r2    (r2_r),
    .dec   (dec),
    .busy  (dist_busy)
  );

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    pop_left_nxt = pop_left_r;
    qx_nxt       = qx_r;
    qy_nxt       = qy_r;
    r2_nxt       = r2_r;
    pend_vld_nxt = pend_vld_r;
    pend_tag_nxt = pend_tag_r;
    out_vld_nxt  = 1'b0;
    out_nxt      = '0;
    pop          = 1'b0;
    push         = 1'b0;
    push_data    = dec.ent;
    wr_idx       = len_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            KIND_ADD: begin
              out_vld_nxt  = 1'b1;
              out_nxt.last = 1'b1;
              if (len_r == CNT_W'(CAPACITY)) begin
                out_nxt.status = STAT_FULL;
              end else begin
                push           = 1'b1;
                push_data.x    = COORD_BITS'(in_data.pos_x);
                push_data.y    = COORD_BITS'(in_data.pos_y);
                push_data.tag  = in_data.tag_in;
                len_nxt        = len_r + CNT_W'(1);
                out_nxt.status = STAT_ADDED;
              end
            end
            KIND_COLLECT: begin
              qx_nxt = COORD_BITS'(in_data.pos_x);
              qy_nxt = COORD_BITS'(in_data.pos_y);
              r2_nxt = R2_W'(in_data.reach) * R2_W'(in_data.reach);
              if (len_r == '0) begin
                out_vld_nxt    = 1'b1;
                out_nxt.status = STAT_NONE;
                out_nxt.last   = 1'b1;
              end else begin
                pop_left_nxt = len_r;
                pend_vld_nxt = 1'b0;
                state_nxt    = ST_SCAN;
              end
            end
            KIND_CLEAR: begin
              len_nxt        = '0;
              out_vld_nxt    = 1'b1;
              out_nxt.status = STAT_CLEARED;
              out_nxt.last   = 1'b1;
            end
            default: begin
              // drop unused operation codes
            end
          endcase
        end
      end

      ST_SCAN: begin
        pop          = (pop_left_r != '0);
        pop_left_nxt = pop_left_r - CNT_W'(pop);
        // kept entries go back in at the tail, behind the unscanned ones
        push         = dec.vld && !dec.hit;
        push_data    = dec.ent;
        wr_idx       = len_r - CNT_W'(pop);
        len_nxt      = len_r - CNT_W'(pop) + CNT_W'(push);

        // hold each hit one step so the final one can carry last
        if (dec.vld && dec.hit) begin
          if (pend_vld_r) begin
            out_vld_nxt     = 1'b1;
            out_nxt.status  = STAT_HIT;
            out_nxt.tag_out = pend_tag_r;
          end
          pend_vld_nxt = 1'b1;
          pend_tag_nxt = dec.ent.tag;
        end

        if (!pop && !dist_busy) begin
          out_vld_nxt  = 1'b1;
          out_nxt.last = 1'b1;
          if (pend_vld_r) begin
            out_nxt.status  = STAT_HIT;
            out_nxt.tag_out = pend_tag_r;
          end else begin
            out_nxt.status = STAT_NONE;
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      len_r      <= '0;
      pop_left_r <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      pop_left_r <= pop_left_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    r2_r       <= r2_nxt;
    pend_tag_r <= pend_tag_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
